[rtl/aksc_pkg.sv]
// Package: shared types, constants and the sequencer states of the spline unit.
package aksc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W = 6;
    localparam int QFRAC = 16;
    localparam logic signed [DATA_W-1:0] SAT_HI = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] SAT_LO = 32'sh80000000;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 34;

    typedef enum logic [13:0] {
        ST_LOAD   = 14'b00000000000001,
        ST_DIFF   = 14'b00000000000010,
        ST_WGT    = 14'b00000000000100,
        ST_SLOPE  = 14'b00000000001000,
        ST_CUBIC  = 14'b00000000010000,
        ST_EMIT   = 14'b00000000100000,
        ST_RD     = 14'b00000001000000,
        ST_RD2    = 14'b00000010000000,
        ST_DIVW   = 14'b00000100000000,
        ST_DIV2   = 14'b00001000000000,
        ST_DIV3   = 14'b00010000000000,
        ST_MUL    = 14'b00100000000000,
        ST_OUT    = 14'b01000000000000,
        ST_TWO    = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic start;
        logic signed [DIV_NUM_W-1:0] num;
        logic signed [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic signed [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DIV_NUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > DIV_NUM_W'(SAT_HI))
            r = SAT_HI;
        else if (v < DIV_NUM_W'(SAT_LO))
            r = SAT_LO;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

[rtl/aksc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module aksc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[rtl/aksc_div.sv]
// Radix-2 restoring signed divider, one quotient bit per cycle, truncates to zero.
module aksc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  aksc_pkg::div_req_t  req,
    output aksc_pkg::div_rsp_t  rsp
);
    import aksc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W:0]   r_reg, r_next;
    logic [DIV_DEN_W-1:0] d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_NUM_W-1:0] anum;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        anum = req.num[DIV_NUM_W-1] ? DIV_NUM_W'(-req.num) : DIV_NUM_W'(req.num);
        trial = {r_reg[DIV_DEN_W-1:0], q_reg[DIV_NUM_W-1]} - {1'b0, d_reg};
        if (req.start)
        begin
            q_next = anum;
            r_next = '0;
            d_next = req.den;
            neg_next = req.num[DIV_NUM_W-1];
            cnt_next = CNT_W'(DIV_NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_DEN_W])
            begin
                r_next = trial;
                q_next = {q_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DIV_DEN_W-1:0], q_reg[DIV_NUM_W-1]};
                q_next = {q_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo = neg_reg ? DIV_NUM_W'(-q_reg) : q_reg;
endmodule

[rtl/akima_spline_coefficients_unit.sv]
// Top level: point store, sequencer and coefficient datapath of the spline unit.
// Loading: one point per cycle while s_axis_tready is high: in loading, with no result pending.
// After the last point, four passes run, then emission; the shared 64-step divider
// sets the pace of the passes.
// Reset: rst_n asynchronous low, clears sequencer, counts and the fault flag.
module akima_spline_coefficients_unit #(
    parameter int MAX_POINTS = aksc_pkg::MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // x_coord, y_value
    input  logic         s_axis_tlast,   // last_point
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // point_index, coef_value..third, pad
    output logic         m_axis_tuser,   // order_error
    output logic         m_axis_tlast    // last_result
);
    import aksc_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic signed [DIV_NUM_W-1:0] SIX = DIV_NUM_W'(6 * 65536);

    state_t st_reg, st_next, ret_reg, ret_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          flt_reg, flt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [1:0]    ph_reg, ph_next;
    logic signed [DATA_W-1:0] lastx_reg, lastx_next;

    // memories: x, y, d, w, s; c2/c3 share one RAM of 64 bits
    logic we_x, we_d, we_w, we_s, we_c;
    logic [AW-1:0] wa_x, wa_d, wa_w, wa_s, wa_c, ra_x, ra_y, ra_d, ra_w, ra_s, ra_c;
    logic [DATA_W-1:0] wd_x, wd_y, wd_d, wd_w, wd_s;
    logic [2*DATA_W-1:0] wd_c, rd_c;
    logic signed [DATA_W-1:0] rd_x, rd_y, rd_d, rd_w, rd_s;

    aksc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_x (.clk, .we(we_x), .waddr(wa_x),
        .wdata(wd_x), .raddr(ra_x), .rdata(rd_x));
    aksc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_y (.clk, .we(we_x), .waddr(wa_x),
        .wdata(wd_y), .raddr(ra_y), .rdata(rd_y));
    aksc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_d (.clk, .we(we_d), .waddr(wa_d),
        .wdata(wd_d), .raddr(ra_d), .rdata(rd_d));
    aksc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_w (.clk, .we(we_w), .waddr(wa_w),
        .wdata(wd_w), .raddr(ra_w), .rdata(rd_w));
    aksc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_s (.clk, .we(we_s), .waddr(wa_s),
        .wdata(wd_s), .raddr(ra_s), .rdata(rd_s));
    aksc_ram #(.WIDTH(2*DATA_W), .DEPTH(MAX_POINTS)) u_c (.clk, .we(we_c), .waddr(wa_c),
        .wdata(wd_c), .raddr(ra_c), .rdata(rd_c));

    div_req_t dreq;
    div_rsp_t drsp;
    aksc_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

    // latched operands a, b, c, e, f, g, h and k
    logic signed [DATA_W-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic signed [DATA_W-1:0] e_reg, e_next, f_reg, f_next, g_reg, g_next;
    logic signed [DATA_W-1:0] h_reg, h_next, k_reg, k_next;
    logic signed [DATA_W:0]   dx_reg, dx_next;
    logic signed [DATA_W:0]   pdx_reg, pdx_next;
    logic signed [DATA_W-1:0] q1_reg, q1_next;
    logic signed [DATA_W-1:0] pc2_reg, pc2_next, pc3_reg, pc3_next;
    logic signed [DIV_NUM_W-1:0] mul_reg, mul_next;
    logic signed [DIV_NUM_W-1:0] bsum_reg, bsum_next;
    logic [DATA_W:0]           wsum_reg, wsum_next;

    logic          ov_reg, ov_next;
    logic [135:0]  od_reg, od_next;
    logic          oe_reg, oe_next, ol_reg, ol_next;

    logic [CW-1:0] n;
    logic s_acc, m_acc;
    logic signed [DATA_W-1:0] xin, yin;
    logic [AW-1:0] iaddr, im1, ip1;
    logic signed [DIV_NUM_W-1:0] t64a, t64b, t64c, d3;
    logic signed [DATA_W-1:0] dqs;

    assign n = cnt_reg;
    assign xin = s_axis_tdata[31:0];
    assign yin = s_axis_tdata[63:32];
    assign s_axis_tready = (st_reg == ST_LOAD) && !ov_reg;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;
    assign m_axis_tuser = oe_reg;
    assign m_axis_tlast = ol_reg;
    assign iaddr = i_reg[AW-1:0];
    assign im1 = AW'(i_reg - 1'b1);
    assign ip1 = AW'(i_reg + 1'b1);
    assign dqs = sat32(drsp.quo);

    function automatic logic signed [DIV_NUM_W-1:0] fshr(input logic signed [DIV_NUM_W-1:0] v);
        return v >>> QFRAC;
    endfunction

    always_comb
    begin
        st_next = st_reg; ret_next = ret_reg; cnt_next = cnt_reg; flt_next = flt_reg;
        i_next = i_reg; ph_next = ph_reg; lastx_next = lastx_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; e_next = e_reg; f_next = f_reg;
        g_next = g_reg; h_next = h_reg; k_next = k_reg; dx_next = dx_reg; pdx_next = pdx_reg;
        q1_next = q1_reg; pc2_next = pc2_reg; pc3_next = pc3_reg; mul_next = mul_reg;
        bsum_next = bsum_reg; wsum_next = wsum_reg;
        ov_next = ov_reg; od_next = od_reg; oe_next = oe_reg; ol_next = ol_reg;
        we_x = 1'b0; we_d = 1'b0; we_w = 1'b0; we_s = 1'b0; we_c = 1'b0;
        wa_x = AW'(cnt_reg); wd_x = xin; wd_y = yin;
        wa_d = iaddr; wd_d = '0; wa_w = iaddr; wd_w = '0; wa_s = iaddr; wd_s = '0;
        wa_c = iaddr; wd_c = '0;
        ra_x = iaddr; ra_y = iaddr; ra_d = iaddr; ra_w = iaddr; ra_s = iaddr; ra_c = iaddr;
        dreq.start = 1'b0; dreq.num = '0; dreq.den = '0;
        t64a = '0; t64b = '0; t64c = '0; d3 = '0;
        if (m_acc)
            ov_next = 1'b0;
        unique case (st_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    if (cnt_reg < CW'(MAX_POINTS))
                    begin
                        we_x = 1'b1;
                        if (cnt_reg != '0 && xin <= lastx_reg)
                            flt_next = 1'b1;
                        lastx_next = xin;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        i_next = '0;
                        ph_next = '0;
                        if (cnt_next >= CW'(2) && !flt_next)
                        begin
                            i_next = CW'(1);
                            st_next = ST_DIFF;
                        end
                        else
                        begin
                            // zero slopes/coeffs for one-point or faulted runs
                            st_next = ST_EMIT;
                        end
                    end
                end
            end
            // pass 1: d[i] = (y[i]-y[i-1])/(x[i]-x[i-1])
            ST_DIFF:
            begin
                ra_x = im1; ra_y = im1;
                ret_next = ST_DIFF;
                st_next = ST_RD;
                ph_next = 2'd0;
            end
            ST_RD:
            begin
                // prev values arrive; read current
                ra_x = iaddr; ra_y = iaddr;
                a_next = rd_x; b_next = rd_y;
                st_next = ST_RD2;
            end
            ST_RD2:
            begin
                dx_next = (DATA_W+1)'(rd_x) - (DATA_W+1)'(a_reg);
                t64a = DIV_NUM_W'(rd_y) - DIV_NUM_W'(b_reg);
                dreq.start = 1'b1;
                dreq.num = t64a <<< QFRAC;
                dreq.den = DIV_DEN_W'((DATA_W+1)'(rd_x) - (DATA_W+1)'(a_reg));
                st_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (drsp.done)
                begin
                    if (cnt_reg == CW'(2))
                    begin
                        // linear case: both slopes equal, coeffs zero
                        we_s = 1'b1; wa_s = '0; wd_s = dqs;
                        a_next = dqs;
                        st_next = ST_TWO;
                    end
                    else
                    begin
                        we_d = 1'b1; wa_d = iaddr; wd_d = dqs;
                        if (i_reg == n - 1'b1)
                        begin
                            i_next = CW'(1);
                            st_next = ST_WGT;
                            ph_next = '0;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            st_next = ST_DIFF;
                        end
                    end
                end
            end
            ST_TWO:
            begin
                we_s = 1'b1; wa_s = AW'(1); wd_s = a_reg;
                we_c = 1'b1; wa_c = '0; wd_c = '0;
                i_next = '0;
                ph_next = '0;
                st_next = ST_EMIT;
            end
            // pass 2: w[i] = |d[i+1]-d[i]|, i = 1..n-2, then ends copied
            ST_WGT:
            begin
                unique case (ph_reg)
                    2'd0:
                    begin
                        ra_d = iaddr; ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        ra_d = ip1; a_next = rd_d; ph_next = 2'd2;
                    end
                    2'd2:
                    begin
                        t64a = DIV_NUM_W'(rd_d) - DIV_NUM_W'(a_reg);
                        if (t64a < 0)
                            t64a = -t64a;
                        we_w = 1'b1; wa_w = iaddr; wd_w = sat32(t64a);
                        if (i_reg == CW'(1))
                        begin
                            // w[0] = w[1]
                            b_next = sat32(t64a);
                        end
                        c_next = sat32(t64a);
                        ph_next = 2'd3;
                    end
                    default:
                    begin
                        if (i_reg == CW'(1))
                        begin
                            we_w = 1'b1; wa_w = '0; wd_w = b_reg;
                        end
                        if (i_reg == n - CW'(2))
                        begin
                            if (i_reg != CW'(1))
                            begin
                                we_w = 1'b1;
                                wa_w = AW'(n - 1'b1);
                                wd_w = c_reg;
                            end
                            else
                            begin
                                // i=1 wrote w0 already this cycle; last next cycle
                            end
                            i_next = (i_reg == CW'(1)) ? CW'(0) : '0;
                            st_next = (i_reg == CW'(1)) ? ST_DIV3 : ST_SLOPE;
                            if (i_reg != CW'(1))
                                ph_next = '0;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            ph_next = '0;
                        end
                    end
                endcase
            end
            ST_DIV3:
            begin
                // n == 3: write w[2] = w[1]
                we_w = 1'b1; wa_w = AW'(n - 1'b1); wd_w = c_reg;
                i_next = '0; ph_next = '0;
                st_next = ST_SLOPE;
            end
            // pass 3: slopes; reads d[i], d[i+1] and w[i-1], w[i+1] for inner points
            ST_SLOPE:
            begin
                unique case (ph_reg)
                    2'd0:
                    begin
                        ra_d = (i_reg == '0) ? AW'(1) : iaddr;
                        ra_w = (i_reg == '0) ? AW'(1) : im1;
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        ra_d = (i_reg == '0) ? AW'(2) :
                               (i_reg == n - 1'b1) ? AW'(n - 2'd2) : ip1;
                        ra_w = (i_reg == '0) ? AW'(0) :
                               (i_reg == n - 1'b1) ? AW'(n - 1'b1) : ip1;
                        a_next = rd_d; b_next = rd_w;
                        ph_next = 2'd2;
                    end
                    default:
                    begin
                        // a = d first, b = w first, rd_d second d, rd_w second w
                        if (i_reg == '0)
                        begin
                            e_next = sat32((DIV_NUM_W'(a_reg) <<< 1) - DIV_NUM_W'(rd_d));
                            f_next = rd_w;   // w0 weights d1
                            g_next = a_reg;  // d1
                            h_next = b_reg;  // w1 weights e
                        end
                        else if (i_reg == n - 1'b1)
                        begin
                            e_next = sat32((DIV_NUM_W'(a_reg) <<< 1) - DIV_NUM_W'(rd_d));
                            f_next = rd_w;   // w[n-1] weights d[n-1]
                            g_next = a_reg;
                            h_next = b_reg;  // w[n-2] weights e
                        end
                        else
                        begin
                            e_next = a_reg;  // d[i], weighted by w[i+1]
                            h_next = rd_w;
                            g_next = rd_d;   // d[i+1], weighted by w[i-1]
                            f_next = b_reg;
                        end
                        st_next = ST_MUL;
                        ph_next = '0;
                    end
                endcase
            end
            ST_MUL:
            begin
                unique case (ph_reg)
                    2'd0:
                    begin
                        mul_next = DIV_NUM_W'(h_reg) * DIV_NUM_W'(e_reg);
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        bsum_next = mul_reg;
                        mul_next = DIV_NUM_W'(f_reg) * DIV_NUM_W'(g_reg);
                        wsum_next = (DATA_W+1)'(h_reg) + (DATA_W+1)'(f_reg);
                        ph_next = 2'd2;
                    end
                    default:
                    begin
                        t64a = bsum_reg + mul_reg;
                        ph_next = '0;
                        if (wsum_reg == '0)
                        begin
                            t64b = (DIV_NUM_W'(e_reg) + DIV_NUM_W'(g_reg)) >>> 1;
                            we_s = 1'b1; wa_s = iaddr; wd_s = sat32(t64b);
                            st_next = ST_OUT;
                        end
                        else
                        begin
                            dreq.start = 1'b1; dreq.num = t64a;
                            dreq.den = DIV_DEN_W'(wsum_reg);
                            st_next = ST_DIV2;
                        end
                    end
                endcase
            end
            ST_DIV2:
            begin
                if (drsp.done)
                begin
                    we_s = 1'b1; wa_s = iaddr; wd_s = dqs;
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (i_reg == n - 1'b1)
                begin
                    i_next = CW'(1);
                    ph_next = '0;
                    st_next = ST_CUBIC;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    st_next = ST_SLOPE;
                end
            end
            // pass 4: c2[i-1], c3[i-1] from s[i-1], s[i], d[i], dx
            ST_CUBIC:
            begin
                unique case (ph_reg)
                    2'd0:
                    begin
                        ra_s = im1; ra_x = im1; ra_d = iaddr;
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        ra_s = iaddr; ra_x = iaddr;
                        a_next = rd_s; b_next = rd_x; c_next = rd_d;
                        ph_next = 2'd2;
                    end
                    2'd2:
                    begin
                        dx_next = (DATA_W+1)'(rd_x) - (DATA_W+1)'(b_reg);
                        d3 = DIV_NUM_W'(a_reg) + DIV_NUM_W'(rd_s) - (DIV_NUM_W'(c_reg) <<< 1);
                        mul_next = d3;
                        t64a = (DIV_NUM_W'(c_reg) - DIV_NUM_W'(a_reg) - d3) <<< 1;
                        dreq.start = 1'b1;
                        dreq.num = t64a <<< QFRAC;
                        dreq.den = DIV_DEN_W'((DATA_W+1)'(rd_x) - (DATA_W+1)'(b_reg));
                        ph_next = 2'd3;
                    end
                    default:
                    begin
                        if (drsp.done)
                        begin
                            k_next = dqs;
                            dreq.start = 1'b1;
                            dreq.num = mul_reg <<< QFRAC;
                            dreq.den = DIV_DEN_W'(dx_reg);
                            st_next = ST_DIV3;
                            ret_next = ST_CUBIC;
                            ph_next = 2'd0;
                        end
                    end
                endcase
                if (ret_reg == ST_CUBIC && ph_reg == 2'd0 && st_reg == ST_CUBIC)
                begin
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || m_acc)
                begin
                    if (ph_reg == 2'd0)
                    begin
                        ra_y = iaddr; ra_s = iaddr; ra_c = iaddr;
                        ph_next = 2'd1;
                    end
                    else
                    begin
                        ov_next = 1'b1;
                        oe_next = flt_reg;
                        ol_next = (i_reg == n - 1'b1);
                        od_next = '0;
                        od_next[IDX_W-1:0] = IDX_W'(i_reg);
                        if (!flt_reg)
                        begin
                            od_next[IDX_W +: DATA_W] = rd_y;
                            od_next[IDX_W+DATA_W +: DATA_W] =
                                (n >= CW'(2)) ? rd_s : '0;
                            od_next[IDX_W+2*DATA_W +: 2*DATA_W] =
                                (n >= CW'(3)) ? rd_c : '0;
                        end
                        ph_next = '0;
                        if (i_reg == n - 1'b1)
                        begin
                            st_next = ST_LOAD;
                            cnt_next = '0;
                            flt_next = 1'b0;
                            i_next = '0;
                        end
                        else
                            i_next = i_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = ST_LOAD;
            end
        endcase

        // second and third divides of the cubic pass share ST_DIV3 with ret_reg
        if (st_reg == ST_DIV3 && ret_reg == ST_CUBIC)
        begin
            we_w = 1'b0;
            st_next = ST_DIV3;
            i_next = i_reg; ph_next = ph_reg;
            unique case (ph_reg)
                2'd0:
                begin
                    if (drsp.done)
                    begin
                        q1_next = dqs;
                        dreq.start = 1'b1;
                        dreq.num = SIX <<< QFRAC;
                        dreq.den = DIV_DEN_W'(dx_reg);
                        ph_next = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (drsp.done)
                    begin
                        mul_next = DIV_NUM_W'(q1_reg) * DIV_NUM_W'(dqs);
                        ph_next = 2'd2;
                    end
                end
                default:
                begin
                    t64c = DIV_NUM_W'(sat32(fshr(mul_reg)));
                    we_c = 1'b1; wa_c = im1;
                    wd_c = {t64c[DATA_W-1:0], k_reg};
                    pc2_next = k_reg; pc3_next = t64c[DATA_W-1:0];
                    pdx_next = dx_reg;
                    ph_next = '0;
                    if (i_reg == n - 1'b1)
                    begin
                        st_next = ST_OUT;
                        ret_next = ST_EMIT;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        st_next = ST_CUBIC;
                    end
                end
            endcase
        end
        // final extrapolated point after cubic pass
        if (st_reg == ST_OUT && ret_reg == ST_EMIT)
        begin
            we_s = 1'b0;
            unique case (ph_reg)
                2'd0:
                begin
                    mul_next = DIV_NUM_W'(pdx_reg) * DIV_NUM_W'(pc3_reg);
                    ph_next = 2'd1;
                    st_next = ST_OUT;
                    i_next = i_reg;
                end
                default:
                begin
                    t64a = DIV_NUM_W'(pc2_reg) + fshr(mul_reg);
                    we_c = 1'b1; wa_c = AW'(n - 1'b1);
                    wd_c = {pc3_reg, sat32(t64a)};
                    i_next = '0; ph_next = '0;
                    ret_next = ST_LOAD;
                    st_next = ST_EMIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_LOAD; ret_reg <= ST_LOAD;
            cnt_reg <= '0; flt_reg <= 1'b0; i_reg <= '0; ph_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; ret_reg <= ret_next;
            cnt_reg <= cnt_next; flt_reg <= flt_next; i_reg <= i_next; ph_reg <= ph_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lastx_reg <= lastx_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; e_reg <= e_next;
        f_reg <= f_next; g_reg <= g_next; h_reg <= h_next; k_reg <= k_next;
        dx_reg <= dx_next; pdx_reg <= pdx_next; q1_reg <= q1_next;
        pc2_reg <= pc2_next; pc3_reg <= pc3_next; mul_reg <= mul_next;
        bsum_reg <= bsum_next; wsum_reg <= wsum_next;
        od_reg <= od_next; oe_reg <= oe_next; ol_reg <= ol_next;
    end

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> !drsp.busy)
        else $error("divider started while busy");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (st_reg == ST_LOAD))
        else $error("load while computing");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count overflow");
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && m_axis_tlast) |=> (cnt_reg == '0 || st_reg == ST_EMIT))
        else $error("count not cleared after run");
endmodule
